FILE: hdl/rct_pkg.sv
package rct_pkg;

  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned ARG_W    = 64;
  localparam int unsigned REFS_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  // result codes
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RAISED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOWERED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;

  // request codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    argument;
    logic [REFS_W-1:0]   refs;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_HIT,
    S_MISS,
    S_MOVE,
    S_FINISH
  } state_t;

endpackage

FILE: hdl/refcounted_callback_table.sv
// Sequence: a zero handle goes straight to the result; otherwise slots are searched in order,
//   then a hit updates the count (moving the last entry into a hole) or a miss appends or reports.
// Throughput: one request at a time; the next is taken in the cycle after the result is loaded,
//   and the result waits in S_FINISH while the result register stalls.
// Reset: synchronous, active high; the table empties at once (fill count cleared),
//   no clearing pass is run over the RAM.
module refcounted_callback_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [rct_pkg::HANDLE_W-1:0]   handle,
  input  logic [rct_pkg::ARG_W-1:0]      argument,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rct_pkg::STATUS_W-1:0]   status,
  output logic                           changed,
  output logic [rct_pkg::COUNT_W-1:0]    entry_count
);

  // AW indexes the RAM, CW holds a count up to DEPTH itself
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = $bits(rct_pkg::entry_t);

  rct_pkg::state_t state, state_next;

  // latched request
  logic                         key_op, key_op_next;
  logic [rct_pkg::HANDLE_W-1:0] key_handle, key_handle_next;
  logic [rct_pkg::ARG_W-1:0]    key_arg, key_arg_next;

  // search sequencer
  logic [CW-1:0] idx, idx_next;       // next slot to read
  logic          rd_valid, rd_valid_next;
  logic [AW-1:0] rd_idx, rd_idx_next; // slot whose data sits on rdata
  logic [AW-1:0] slot, slot_next;     // matching slot
  logic [rct_pkg::REFS_W-1:0] hit_refs, hit_refs_next;

  // fill count; entries at or above it are never used, so the RAM needs no clear
  logic [CW-1:0] occ, occ_next;

  logic [rct_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic                         res_changed, res_changed_next;

  logic                           out_valid_next;
  logic [rct_pkg::STATUS_W-1:0]   status_next;
  logic                           changed_next;
  logic [rct_pkg::COUNT_W-1:0]    entry_count_next;

  // RAM port
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  rct_pkg::entry_t ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  rct_pkg::entry_t rd_entry;

  logic [CW-1:0] last;
  logic [AW-1:0] last_addr;

  assign rd_entry  = rct_pkg::entry_t'(ram_rdata);
  assign last      = occ - CW'(1);
  assign last_addr = last[AW-1:0];
  assign in_stall  = (state != rct_pkg::S_IDLE);

  rct_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rct_pkg::S_IDLE;
      occ       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      rd_valid  <= rd_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key_op      <= key_op_next;
    key_handle  <= key_handle_next;
    key_arg     <= key_arg_next;
    idx         <= idx_next;
    rd_idx      <= rd_idx_next;
    slot        <= slot_next;
    hit_refs    <= hit_refs_next;
    res_status  <= res_status_next;
    res_changed <= res_changed_next;
    status      <= status_next;
    changed     <= changed_next;
    entry_count <= entry_count_next;
  end

  always_comb begin
    state_next       = state;
    key_op_next      = key_op;
    key_handle_next  = key_handle;
    key_arg_next     = key_arg;
    idx_next         = idx;
    rd_valid_next    = 1'b0;
    rd_idx_next      = rd_idx;
    slot_next        = slot;
    hit_refs_next    = hit_refs;
    occ_next         = occ;
    res_status_next  = res_status;
    res_changed_next = res_changed;
    status_next      = status;
    changed_next     = changed;
    entry_count_next = entry_count;
    // result register drains on a transfer
    out_valid_next   = out_valid && out_stall;

    ram_we             = 1'b0;
    ram_waddr          = slot;
    ram_wdata.handle   = key_handle;
    ram_wdata.argument = key_arg;
    ram_wdata.refs     = hit_refs;
    ram_raddr          = idx[AW-1:0];

    case (state)
      rct_pkg::S_IDLE: begin
        if (in_valid) begin
          key_op_next     = op;
          key_handle_next = handle;
          key_arg_next    = argument;
          idx_next        = '0;
          if (handle == '0) begin
            // zero handle never matches and is never stored
            res_status_next  = rct_pkg::ST_NOTFOUND;
            res_changed_next = 1'b0;
            state_next       = rct_pkg::S_FINISH;
          end else begin
            state_next = rct_pkg::S_SEARCH;
          end
        end
      end

      rct_pkg::S_SEARCH: begin
        // read slot idx while comparing the previously read slot
        if (rd_valid && rd_entry.handle == key_handle && rd_entry.argument == key_arg) begin
          slot_next     = rd_idx;
          hit_refs_next = rd_entry.refs;
          state_next    = rct_pkg::S_HIT;
        end else if (!rd_valid && idx == occ) begin
          state_next = rct_pkg::S_MISS;
        end else if (idx < occ) begin
          rd_valid_next = 1'b1;
          rd_idx_next   = idx[AW-1:0];
          idx_next      = idx + CW'(1);
        end
      end

      rct_pkg::S_HIT: begin
        res_changed_next = 1'b0;
        state_next       = rct_pkg::S_FINISH;
        if (key_op == rct_pkg::OP_ADD) begin
          ram_we         = 1'b1;
          ram_wdata.refs = (hit_refs == rct_pkg::REFS_MAX) ? hit_refs
                                                           : hit_refs + 1'b1;
          res_status_next = rct_pkg::ST_RAISED;
        end else if (hit_refs > rct_pkg::REFS_W'(1)) begin
          ram_we          = 1'b1;
          ram_wdata.refs  = hit_refs - 1'b1;
          res_status_next = rct_pkg::ST_LOWERED;
        end else if (slot == last_addr) begin
          // removing the last entry: just shrink
          occ_next         = last;
          res_status_next  = rct_pkg::ST_REMOVED;
          res_changed_next = 1'b1;
        end else begin
          // fetch the last entry to fill the hole
          ram_raddr  = last_addr;
          state_next = rct_pkg::S_MOVE;
        end
      end

      rct_pkg::S_MOVE: begin
        ram_we           = 1'b1;
        ram_wdata        = rd_entry;
        occ_next         = last;
        res_status_next  = rct_pkg::ST_REMOVED;
        res_changed_next = 1'b1;
        state_next       = rct_pkg::S_FINISH;
      end

      rct_pkg::S_MISS: begin
        res_changed_next = 1'b0;
        state_next       = rct_pkg::S_FINISH;
        if (key_op == rct_pkg::OP_REMOVE) begin
          res_status_next = rct_pkg::ST_NOTFOUND;
        end else if (occ >= CW'(DEPTH)) begin
          res_status_next = rct_pkg::ST_OVERFLOW;
        end else begin
          // append at the first free slot
          ram_we           = 1'b1;
          ram_waddr        = occ[AW-1:0];
          ram_wdata.refs   = rct_pkg::REFS_W'(1);
          occ_next         = occ + CW'(1);
          res_status_next  = rct_pkg::ST_NEW;
          res_changed_next = 1'b1;
        end
      end

      rct_pkg::S_FINISH: begin
        // wait for room in the result register
        if (!out_valid || !out_stall) begin
          out_valid_next   = 1'b1;
          status_next      = res_status;
          changed_next     = res_changed;
          entry_count_next = rct_pkg::COUNT_W'(occ);
          state_next       = rct_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = rct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/rct_ram.sv
module rct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
